FILE: design/bgma_pkg.sv
// Package for the battery gauge moving-average unit.
// Field widths, register reset values, codes and percent thresholds.
// No dependencies.
package bgma_pkg;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned PROD_W = ADC_W + GAIN_W;
  localparam int unsigned ICON_W = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL  = 2'd0,
    CFG_FULL_LEVEL   = 2'd1,
    CFG_PERCENT_GAIN = 2'd2,
    CFG_UPDATE_STEP  = 2'd3
  } cfg_idx_e;

  localparam logic [ADC_W-1:0]  EMPTY_LEVEL_RST  = 12'd3284;
  localparam logic [ADC_W-1:0]  FULL_LEVEL_RST   = 12'd3831;
  localparam logic [GAIN_W-1:0] PERCENT_GAIN_RST = 16'd11981;
  localparam logic [PCT_W-1:0]  UPDATE_STEP_RST  = 7'd10;

  // Item kinds, carried on the slave tuser
  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_REFRESH = 1'b1
  } kind_e;

  localparam logic [PCT_W-1:0] FULL_PCT  = 7'd99;
  localparam logic [PCT_W-1:0] ICON3_PCT = 7'd75;
  localparam logic [PCT_W-1:0] ICON2_PCT = 7'd50;
  localparam logic [PCT_W-1:0] ICON1_PCT = 7'd25;

  localparam logic [ICON_W-1:0] ICON_EMPTY = 2'd0;
  localparam logic [ICON_W-1:0] ICON_LOW   = 2'd1;
  localparam logic [ICON_W-1:0] ICON_HALF  = 2'd2;
  localparam logic [ICON_W-1:0] ICON_FULL  = 2'd3;

  // Stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  function automatic logic [ICON_W-1:0] icon_of(input logic [PCT_W-1:0] pct);
    logic [ICON_W-1:0] icon;
    if (pct >= ICON3_PCT)      icon = ICON_FULL;
    else if (pct >= ICON2_PCT) icon = ICON_HALF;
    else if (pct >= ICON1_PCT) icon = ICON_LOW;
    else                       icon = ICON_EMPTY;
    return icon;
  endfunction

endpackage

FILE: design/battery_gauge_moving_average_unit.sv
// Battery gauge: moving average over a sample ring, percent mapping, display hysteresis.
// Depends on bgma_pkg.
//
//  channel  dir  handshake             payload
//  s_axis   in   tvalid/tready         tdata: adc_sample, charging; tuser: kind
//  m_axis   out  tvalid/tready         tdata: live, shown, icon, charging, changed
//  cfg      in   cfg_we_i (no ready)   cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained; each beat goes through the stage 1, 2, 3 and output registers.
// The ring memory is read-first: the old entry is read and the new one written
// at the accept edge, the running sum is updated on leaving stage 1, then the multiply.
// Reset clears ring valid bits, so unwritten entries read as zero at once.
// The whole pipe stalls only while the output register holds an untaken beat.
module battery_gauge_moving_average_unit #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [bgma_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bgma_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bgma_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [11:0] adc_sample, [12] charging
  input  logic                                s_axis_tuser,  // [0] kind
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bgma_pkg::M_TDATA_W-1:0]      m_axis_tdata   // [6:0] live_percent,
                                                             // [13:7] shown_percent,
                                                             // [15:14] icon_level,
                                                             // [16] charging_mark,
                                                             // [17] shown_changed
);

  localparam int unsigned ADC_W  = bgma_pkg::ADC_W;
  localparam int unsigned PCT_W  = bgma_pkg::PCT_W;
  localparam int unsigned GAIN_W = bgma_pkg::GAIN_W;
  localparam int unsigned PROD_W = bgma_pkg::PROD_W;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = ADC_W + SLOT_W;

  // config registers
  logic [ADC_W-1:0]  empty_level_q;
  logic [ADC_W-1:0]  full_level_q;
  logic [GAIN_W-1:0] percent_gain_q;
  logic [PCT_W-1:0]  update_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_level_q  <= bgma_pkg::EMPTY_LEVEL_RST;
      full_level_q   <= bgma_pkg::FULL_LEVEL_RST;
      percent_gain_q <= bgma_pkg::PERCENT_GAIN_RST;
      update_step_q  <= bgma_pkg::UPDATE_STEP_RST;
    end else if (cfg_we_i) begin
      case (bgma_pkg::cfg_idx_e'(cfg_idx_i))
        bgma_pkg::CFG_EMPTY_LEVEL:  empty_level_q  <= cfg_wdata_i[ADC_W-1:0];
        bgma_pkg::CFG_FULL_LEVEL:   full_level_q   <= cfg_wdata_i[ADC_W-1:0];
        bgma_pkg::CFG_PERCENT_GAIN: percent_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        bgma_pkg::CFG_UPDATE_STEP:  update_step_q  <= cfg_wdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe control
  logic adv;
  logic in_acc;
  logic out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  logic             in_kind;
  logic [ADC_W-1:0] in_sample;
  logic             in_chg;
  logic             in_is_sample;

  assign in_kind      = s_axis_tuser;
  assign in_sample    = s_axis_tdata[ADC_W-1:0];
  assign in_chg       = s_axis_tdata[ADC_W];
  assign in_is_sample = (bgma_pkg::kind_e'(in_kind) == bgma_pkg::KIND_SAMPLE);

  // stage 0: ring access
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WINDOW-1:0] ring_vld_q, ring_vld_d;
  logic [ADC_W-1:0]  ring_mem [WINDOW];
  logic [ADC_W-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic              ring_wr;

  assign ring_wr = in_acc && in_is_sample;

  always_comb begin
    slot_d     = slot_q;
    ring_vld_d = ring_vld_q;
    if (ring_wr) begin
      slot_d             = slot_q + 1'b1;
      ring_vld_d[slot_q] = 1'b1;
    end
  end

  // read-first: old entry comes out while the new sample goes in
  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_mem[slot_q] <= in_sample;
      rd_data_q        <= ring_mem[slot_q];
    end
  end

  // stage 1 payload
  logic             s1_vld_q;
  logic             s1_kind_q;
  logic             s1_chg_q;
  logic [ADC_W-1:0] s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      ring_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      s1_vld_q   <= 1'b0;
    end else begin
      slot_q     <= slot_d;
      ring_vld_q <= ring_vld_q & ring_vld_d | ring_vld_d;
      if (ring_wr) rd_vld_q <= ring_vld_q[slot_q];
      if (adv)     s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= in_kind;
      s1_chg_q    <= in_chg;
      s1_sample_q <= in_sample;
    end
  end

  // stage 1: running sum
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [ADC_W-1:0] old_entry;
  logic             s1_is_sample;

  assign old_entry    = rd_vld_q ? rd_data_q : '0;
  assign s1_is_sample = (bgma_pkg::kind_e'(s1_kind_q) == bgma_pkg::KIND_SAMPLE);

  always_comb begin
    sum_d = sum_q;
    if (adv && s1_vld_q && s1_is_sample) begin
      sum_d = sum_q - SUM_W'(old_entry) + SUM_W'(s1_sample_q);
    end
  end

  logic s2_vld_q;
  logic s2_kind_q;
  logic s2_chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      s2_vld_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      if (adv) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      s2_kind_q <= s1_kind_q;
      s2_chg_q  <= s1_chg_q;
    end
  end

  // stage 2: average, level tests and gain multiply
  logic [ADC_W-1:0]  avg;
  logic [ADC_W-1:0]  avg_above;
  logic [PROD_W-1:0] prod_d;

  assign avg       = sum_q[SUM_W-1:SLOT_W];
  assign avg_above = avg - empty_level_q;
  assign prod_d    = PROD_W'(avg_above) * PROD_W'(percent_gain_q);

  logic              s3_vld_q;
  logic              s3_kind_q;
  logic              s3_chg_q;
  logic              s3_full_q;
  logic              s3_empty_q;
  logic [PROD_W-1:0] s3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      s3_kind_q  <= s2_kind_q;
      s3_chg_q   <= s2_chg_q;
      s3_full_q  <= (avg >= full_level_q);
      s3_empty_q <= (avg <= empty_level_q);
      s3_prod_q  <= prod_d;
    end
  end

  // stage 3: percent, hysteresis, output register
  logic [PCT_W-1:0]       live_q, live_d;
  logic [PCT_W-1:0]       shown_q, shown_d;
  logic                   changed_d;
  logic [ADC_W-1:0]       pct_raw;
  logic [PCT_W-1:0]       pct_map;
  logic [PCT_W-1:0]       pct_diff;
  logic                   s3_is_sample;

  assign s3_is_sample = (bgma_pkg::kind_e'(s3_kind_q) == bgma_pkg::KIND_SAMPLE);
  assign pct_raw      = s3_prod_q[PROD_W-1:GAIN_W];
  assign pct_diff     = (live_q >= shown_q) ? (live_q - shown_q) : (shown_q - live_q);

  always_comb begin
    if (s3_full_q)                               pct_map = bgma_pkg::FULL_PCT;
    else if (s3_empty_q)                         pct_map = '0;
    else if (pct_raw > ADC_W'(bgma_pkg::FULL_PCT)) pct_map = bgma_pkg::FULL_PCT;
    else                                         pct_map = pct_raw[PCT_W-1:0];
  end

  always_comb begin
    live_d    = live_q;
    shown_d   = shown_q;
    changed_d = 1'b0;
    if (s3_is_sample) begin
      live_d = pct_map;
    end else if (pct_diff >= update_step_q) begin
      shown_d   = live_q;
      changed_d = 1'b1;
    end
  end

  logic [PCT_W-1:0]            out_live_q;
  logic [PCT_W-1:0]            out_shown_q;
  logic [bgma_pkg::ICON_W-1:0] out_icon_q;
  logic                        out_chg_q;
  logic                        out_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      shown_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s3_vld_q;
      if (s3_vld_q) begin
        live_q  <= live_d;
        shown_q <= shown_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_vld_q) begin
      out_live_q    <= live_d;
      out_shown_q   <= shown_d;
      out_icon_q    <= bgma_pkg::icon_of(shown_d);
      out_chg_q     <= s3_chg_q;
      out_changed_q <= changed_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_changed_q, out_chg_q, out_icon_q, out_shown_q, out_live_q};

endmodule
